/* rtl/htbd_pkg.sv */
package htbd_pkg;

  // fixed field widths of the channels
  localparam int unsigned CODE_W = 16;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned MODE_W = 2;

  // transaction modes
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECODE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMIT       = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_PREFIX = 3'd2;
  localparam logic [STAT_W-1:0] ST_MISSING    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic              load;       // capture input transaction
    logic              clear;      // empty root, reset allocator and walk
    logic              restart;    // walk back to root
    logic              dec_read;   // read child node for decode
    logic              dec_eval;   // move walk from read child
    logic              ins_follow; // follow existing child on insert
    logic              ins_latch;  // capture read child entry
    logic              ins_alloc;  // create child and descend
    logic              ins_store;  // store symbol at current node
    logic              ins_flush;  // write back pending node, walk to root
    logic              finish;     // result known
    logic [STAT_W-1:0] res_code;
    logic              out_load;   // move held result into output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              bits_done;
    logic              cur_has_sym;
    logic              link_zero;
    logic              table_full;
    logic              rd_has_sym;
    logic              out_free;
  } sts_t;

endpackage

/* rtl/huffman_tree_build_and_bit_decode_top.sv */
// steps: clear/restart finish at dispatch; decode reads the child at dispatch, then evaluates it
// (a missing branch ends at dispatch); insert takes an alloc step per created node or a follow
// and read step per existing node, then stores; one transaction at a time, next input taken
// once the result is in the output register; registered node memory reads pace decode and insert
// reset (rst_ni low, asynchronous): empty root, one node in use, walk at root, no result pending
// no memory sweep after reset: the root lives in flops, other nodes are written on allocation
module huffman_tree_build_and_bit_decode_top #(
  parameter int unsigned MAX_NODES    = 512,
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_BITS  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transaction channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [htbd_pkg::MODE_W-1:0] mode_i,
  input  logic [htbd_pkg::SYM_W-1:0]  symbol_i,
  input  logic [htbd_pkg::CODE_W-1:0] code_bits_i,
  input  logic [htbd_pkg::LEN_W-1:0]  code_length_i,
  input  logic                        bit_req_i,
  // result transaction channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [htbd_pkg::STAT_W-1:0] status_o,
  output logic [htbd_pkg::SYM_W-1:0]  out_symbol_o
);
  import htbd_pkg::*;

  // command and status between the sequencer and the tree datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: walks one tree level per step, one memory read outstanding at most
  htbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: node memory, root entry, allocator, walk pointer and result registers
  htbd_dp #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_BITS  (SYMBOL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .bit_req_i     (bit_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_symbol_o  (out_symbol_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

/* rtl/htbd_ram.sv */
module htbd_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/htbd_ctrl.sv */
module htbd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  htbd_pkg::sts_t  sts_i,
  output htbd_pkg::cmd_t  cmd_o
);
  import htbd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS_STEP = 3'd2;
  localparam logic [2:0] S_INS_READ = 3'd3;
  localparam logic [2:0] S_DEC_EVAL = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fin_next;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    fin_next = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.mode)
          MODE_CLEAR: begin
            cmd_o.clear    = 1'b1;
            cmd_o.res_code = ST_OK;
            fin_next       = 1'b1;
          end
          MODE_INSERT: begin
            // insert always walks from the root
            cmd_o.restart = 1'b1;
            state_d       = S_INS_STEP;
          end
          MODE_DECODE: begin
            if (sts_i.link_zero) begin
              cmd_o.restart  = 1'b1;
              cmd_o.res_code = ST_MISSING;
              fin_next       = 1'b1;
            end else begin
              cmd_o.dec_read = 1'b1;
              state_d        = S_DEC_EVAL;
            end
          end
          default: begin
            cmd_o.restart  = 1'b1;
            cmd_o.res_code = ST_OK;
            fin_next       = 1'b1;
          end
        endcase
      end
      S_INS_STEP: begin
        if (sts_i.bits_done) begin
          cmd_o.ins_store = 1'b1;
          cmd_o.res_code  = ST_OK;
          fin_next        = 1'b1;
        end else if (sts_i.cur_has_sym) begin
          cmd_o.ins_flush = 1'b1;
          cmd_o.res_code  = ST_NOT_PREFIX;
          fin_next        = 1'b1;
        end else if (!sts_i.link_zero) begin
          cmd_o.ins_follow = 1'b1;
          state_d          = S_INS_READ;
        end else if (sts_i.table_full) begin
          cmd_o.ins_flush = 1'b1;
          cmd_o.res_code  = ST_FULL;
          fin_next        = 1'b1;
        end else begin
          cmd_o.ins_alloc = 1'b1;
        end
      end
      S_INS_READ: begin
        cmd_o.ins_latch = 1'b1;
        state_d         = S_INS_STEP;
      end
      S_DEC_EVAL: begin
        cmd_o.dec_eval = 1'b1;
        cmd_o.res_code = sts_i.rd_has_sym ? ST_EMIT : ST_OK;
        fin_next       = 1'b1;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin_next) begin
      cmd_o.finish = 1'b1;
      state_d      = sts_i.out_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/htbd_dp.sv */
module htbd_dp #(
  parameter int unsigned MAX_NODES    = 512,
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [htbd_pkg::MODE_W-1:0]   mode_i,
  input  logic [htbd_pkg::SYM_W-1:0]    symbol_i,
  input  logic [htbd_pkg::CODE_W-1:0]   code_bits_i,
  input  logic [htbd_pkg::LEN_W-1:0]    code_length_i,
  input  logic                          bit_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [htbd_pkg::STAT_W-1:0]   status_o,
  output logic [htbd_pkg::SYM_W-1:0]    out_symbol_o,
  input  htbd_pkg::cmd_t                cmd_i,
  output htbd_pkg::sts_t                sts_o
);
  import htbd_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_NODES);
  localparam int unsigned CNT_W   = $clog2(MAX_NODES + 1);
  localparam int unsigned SYM_EXT = (SYMBOL_BITS > SYM_W) ? SYMBOL_BITS : SYM_W;

  typedef struct packed {
    logic                   has_sym;
    logic [SYMBOL_BITS-1:0] sym;
    logic [IDX_W-1:0]       link1;
    logic [IDX_W-1:0]       link0;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  // captured transaction
  logic [MODE_W-1:0]      mode_q;
  logic [SYMBOL_BITS-1:0] sym_in_q;
  logic [CODE_W-1:0]      code_q;
  logic [LEN_W-1:0]       left_q;
  logic                   bit_q;

  // tree and walk state
  ent_t                   root_q;
  ent_t                   ent_q;
  logic                   dirty_q;
  logic [IDX_W-1:0]       node_q;
  logic [CNT_W-1:0]       used_q;

  // result holding and output registers
  logic [STAT_W-1:0]      res_code_q;
  logic [SYM_W-1:0]       res_sym_q;
  logic                   out_valid_q;
  logic [STAT_W-1:0]      out_code_q;
  logic [SYM_W-1:0]       out_sym_q;

  logic [SYM_EXT-1:0]     sym_in_ext;
  logic [SYM_EXT-1:0]     rd_sym_ext;
  logic [LEN_W-1:0]       len_clip;
  logic [LEN_W-1:0]       pos;
  logic                   ins_bit;
  logic                   dir;
  logic                   at_root;
  ent_t                   cur_ent;
  ent_t                   alloc_ent;
  ent_t                   store_ent;
  ent_t                   empty_ent;
  ent_t                   rd_ent;
  logic [ENT_W-1:0]       rd_data;
  logic [IDX_W-1:0]       link;
  logic [IDX_W-1:0]       new_idx;
  logic [SYM_W-1:0]       fin_sym;
  logic                   out_free;
  logic                   wr_en;
  ent_t                   wr_ent;
  logic                   rd_en;

  assign sym_in_ext = SYM_EXT'(symbol_i);
  assign len_clip   = (32'(code_length_i) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                          : code_length_i;
  assign empty_ent  = '0;

  assign at_root = (node_q == '0);
  assign cur_ent = at_root ? root_q : ent_q;

  // next codeword bit, positions above the field read as zero
  assign pos     = left_q - LEN_W'(1);
  assign ins_bit = pos[LEN_W-1] ? 1'b0 : code_q[pos[LEN_W-2:0]];
  assign dir     = (mode_q == MODE_DECODE) ? bit_q : ins_bit;
  assign link    = dir ? cur_ent.link1 : cur_ent.link0;
  assign new_idx = used_q[IDX_W-1:0];

  always_comb begin
    alloc_ent = cur_ent;
    if (dir) begin
      alloc_ent.link1 = new_idx;
    end else begin
      alloc_ent.link0 = new_idx;
    end
    store_ent         = cur_ent;
    store_ent.has_sym = 1'b1;
    store_ent.sym     = sym_in_q;
  end

  assign rd_ent     = ent_t'(rd_data);
  assign rd_sym_ext = SYM_EXT'(rd_ent.sym);
  assign fin_sym    = (cmd_i.res_code == ST_EMIT) ? rd_sym_ext[SYM_W-1:0] : '0;

  assign out_free = !out_valid_q || !out_stall_i;

  // one port write: new link, stored symbol or pending fresh node
  assign wr_en  = !at_root &&
                  (cmd_i.ins_alloc || cmd_i.ins_store || (cmd_i.ins_flush && dirty_q));
  assign wr_ent = cmd_i.ins_alloc ? alloc_ent : (cmd_i.ins_store ? store_ent : ent_q);
  assign rd_en  = cmd_i.dec_read || cmd_i.ins_follow;

  htbd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (node_q),
    .wr_data_i (wr_ent),
    .rd_en_i   (rd_en),
    .rd_addr_i (link),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      sym_in_q <= sym_in_ext[SYMBOL_BITS-1:0];
      code_q   <= code_bits_i;
      left_q   <= len_clip;
      bit_q    <= bit_req_i;
    end else if (cmd_i.ins_alloc || cmd_i.ins_follow) begin
      left_q <= pos;
    end
    if (cmd_i.ins_alloc) begin
      ent_q <= empty_ent;
    end else if (cmd_i.ins_latch || cmd_i.dec_eval) begin
      ent_q <= rd_ent;
    end
    if (cmd_i.finish) begin
      res_code_q <= cmd_i.res_code;
      res_sym_q  <= fin_sym;
    end
    if (cmd_i.finish && out_free) begin
      out_code_q <= cmd_i.res_code;
      out_sym_q  <= fin_sym;
    end else if (cmd_i.out_load) begin
      out_code_q <= res_code_q;
      out_sym_q  <= res_sym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      node_q      <= '0;
      used_q      <= CNT_W'(1);
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        root_q <= '0;
        used_q <= CNT_W'(1);
        node_q <= '0;
      end
      if (cmd_i.restart || cmd_i.ins_store || cmd_i.ins_flush) begin
        node_q <= '0;
      end
      if (cmd_i.ins_alloc) begin
        if (at_root) begin
          root_q <= alloc_ent;
        end
        node_q  <= new_idx;
        used_q  <= used_q + CNT_W'(1);
        dirty_q <= 1'b1;
      end
      if (cmd_i.ins_store && at_root) begin
        root_q <= store_ent;
      end
      if (cmd_i.ins_follow || cmd_i.ins_store || cmd_i.ins_flush) begin
        dirty_q <= 1'b0;
      end
      if (cmd_i.ins_follow) begin
        node_q <= link;
      end
      if (cmd_i.dec_eval) begin
        node_q <= rd_ent.has_sym ? '0 : link;
      end
      if ((cmd_i.finish && out_free) || cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mode        = mode_q;
  assign sts_o.bits_done   = (left_q == '0);
  assign sts_o.cur_has_sym = cur_ent.has_sym;
  assign sts_o.link_zero   = (link == '0);
  assign sts_o.table_full  = (used_q >= CNT_W'(MAX_NODES));
  assign sts_o.rd_has_sym  = rd_ent.has_sym;
  assign sts_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_code_q;
  assign out_symbol_o = out_sym_q;

endmodule
